// ----- design/sse_pkg.sv -----
package sse_pkg;

  localparam int unsigned PosW = 4;

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [15:0] PatDot  = 16'h0080;
  localparam logic [15:0] PatDash = 16'h0040;
  localparam logic [15:0] PatNone = 16'h0000;

  localparam logic [15:0] LetterFont [26] = '{
    16'h00F7, 16'h128F, 16'h0039, 16'h120F, 16'h00F9, 16'h00F1, 16'h00BD,
    16'h00F6, 16'h1209, 16'h001E, 16'h2470, 16'h0038, 16'h0536, 16'h2136,
    16'h003F, 16'h00F3, 16'h203F, 16'h20F3, 16'h018D, 16'h1201, 16'h003E,
    16'h0C30, 16'h2836, 16'h2D00, 16'h1500, 16'h0C09
  };

  localparam logic [15:0] DigitFont [10] = '{
    16'h003F, 16'h0006, 16'h005B, 16'h004F, 16'h0066,
    16'h006D, 16'h007D, 16'h0007, 16'h007F, 16'h006F
  };

  typedef struct packed {
    logic            emit;
    logic [PosW-1:0] position;
    logic [15:0]     pattern;
  } res_t;

  function automatic logic [15:0] font_lookup(input logic [7:0] ch);
    logic [7:0]  off;
    logic [15:0] pat;
    off = 8'h00;
    pat = PatNone;
    if (ch inside {[CharUpA:CharUpZ]}) begin
      off = ch - CharUpA;
      pat = LetterFont[off[4:0]];
    end else if (ch inside {[CharLoA:CharLoZ]}) begin
      off = ch - CharLoA;
      pat = LetterFont[off[4:0]];
    end else if (ch inside {[CharZero:CharNine]}) begin
      off = ch - CharZero;
      pat = DigitFont[off[3:0]];
    end else if (ch == CharDash) begin
      pat = PatDash;
    end
    return pat;
  endfunction

endpackage

// ----- design/sse_core.sv -----
module sse_core #(
  parameter int unsigned DIGITS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_en_i,
  input  logic [7:0]    character_i,
  input  logic          start_of_string_i,
  output sse_pkg::res_t res_o
);

  logic [sse_pkg::PosW-1:0] next_pos_q, next_pos_d, pos_cur;
  logic [15:0]              prev_pat_q, prev_pat_d, prev_pat_cur;
  logic                     prev_space_q, prev_space_d, prev_space_cur;
  logic [15:0]              font;
  logic                     is_dot, merge;

  always_comb begin
    pos_cur        = start_of_string_i ? '0 : next_pos_q;
    prev_pat_cur   = start_of_string_i ? '0 : prev_pat_q;
    prev_space_cur = start_of_string_i ? 1'b0 : prev_space_q;
    font           = sse_pkg::font_lookup(character_i);
    is_dot         = (character_i == sse_pkg::CharDot);
    merge          = is_dot && (pos_cur != '0) && !prev_space_cur;

    res_o.emit     = 1'b0;
    res_o.position = pos_cur;
    res_o.pattern  = font;
    next_pos_d     = pos_cur;
    prev_pat_d     = prev_pat_cur;
    prev_space_d   = prev_space_cur;

    if (merge) begin
      // fold the decimal point into the previous position
      res_o.emit     = 1'b1;
      res_o.position = pos_cur - 1'b1;
      res_o.pattern  = prev_pat_cur | sse_pkg::PatDot;
      prev_pat_d     = font;
      prev_space_d   = (character_i == sse_pkg::CharSpace);
    end else if (pos_cur < sse_pkg::PosW'(DIGITS)) begin
      res_o.emit     = 1'b1;
      res_o.pattern  = is_dot ? sse_pkg::PatDot : font;
      next_pos_d     = pos_cur + 1'b1;
      prev_pat_d     = font;
      prev_space_d   = (character_i == sse_pkg::CharSpace);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_pos_q   <= '0;
      prev_pat_q   <= '0;
      prev_space_q <= 1'b0;
    end else if (item_en_i) begin
      next_pos_q   <= next_pos_d;
      prev_pat_q   <= prev_pat_d;
      prev_space_q <= prev_space_d;
    end
  end

endmodule

// ----- design/segment_string_encoder.sv -----
// Path: a character is taken into the input register, then its result into
//   the result register; a downstream stall holds the item in the input register.
// Throughput: one character per cycle while no result is held off by out_stall_i;
//   the core's position and previous-character update does not throttle it.
// Reset: rst_ni clears both valid flags and the string state (position 0,
//   previous pattern 0, previous character not a space); payloads are not reset.
module segment_string_encoder #(
  parameter int unsigned DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        start_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  digit_position_o,
  output logic [3:0]  ram_address_o,
  output logic [15:0] pattern_o
);

  // Input stage: one item held for the core.
  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        sos_q;

  // Result stage.
  logic        out_valid_q;
  logic [2:0]  pos_q;
  logic [15:0] pat_q;

  logic          advance;
  sse_pkg::res_t res;

  // The held item moves on when the result slot is free or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Load payload only with a new item; hold it while stalled.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= character_i;
      sos_q  <= start_of_string_i;
    end
  end

  // Font lookup, dot merge and position update; state advances per item.
  sse_core #(
    .DIGITS(DIGITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_en_i        (in_valid_q && advance),
    .character_i      (char_q),
    .start_of_string_i(sos_q),
    .res_o            (res)
  );

  // An item that writes nothing (display full) just drops out here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res.emit) begin
      pos_q <= res.position[2:0];
      pat_q <= res.pattern;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign digit_position_o = pos_q;
  assign ram_address_o    = {pos_q, 1'b0};
  assign pattern_o        = pat_q;

  // A write never lands beyond the last display position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, digit_position_o} < sse_pkg::PosW'(DIGITS)))
    else $error("segment write beyond last position");

  // Input backs up only when a result is waiting and held off downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A stalled result stays valid and keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(digit_position_o) && $stable(pattern_o)))
    else $error("stalled result changed or dropped");

endmodule
